// ----- hw/rtl/three_button_debounce_long_press_macros.svh -----
// Assertion macros shared by the button debounce block.
`ifndef THREE_BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define THREE_BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset.
`define TBDLP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true at a clock edge out of reset.
`define TBDLP_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TBDLP_ASSERT(label, clk, rst_n, prop, msg)

`define TBDLP_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ----- hw/rtl/tbdlp_pkg.sv -----
// Types and constants of the button debounce block.
package tbdlp_pkg;

    // Configuration register widths and data port width.
    localparam int DEBOUNCE_W = 10;
    localparam int WINDOW_W   = 16;
    localparam int HOLD_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd2;

    // Register values after reset.
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 16'd1000;
    localparam logic [HOLD_W-1:0]     HOLD_RESET     = 16'd3000;

    // Accepted level changes of one button on one tick.
    typedef struct packed {
        logic pressed;
        logic released;
    } db_evt_t;

    // Result of one tick.
    typedef struct packed {
        logic [1:0] wake_count;
        logic       plus_event;
        logic       minus_event;
        logic       short_reset_event;
        logic       format_event;
    } tick_res_t;

endpackage

// ----- hw/rtl/three_button_debounce_long_press.sv -----
// Top level of the three-button debounce with wake guard and long-press reset.
//
// Channel | Handshake             | Payload
// --------+-----------------------+-------------------------------------------
// in      | in_valid / in_ready   | plus_raw, minus_raw, reset_raw, display_on
// out     | out_valid / out_ready | wake_count, plus_event, minus_event,
//         |                       | short_reset_event, format_event
// cfg     | cfg_wr_en             | cfg_index, cfg_data
//
// One request per cycle is accepted unless the input register is stalled;
// its result is offered after the input register and then the result register.
// A request can be taken while the last result still waits to be read.
// A stalled result holds the result register; the input register keeps
// accepting until it also fills.
// Reset clears the tick counter, all stamps and the hold state, sets the
// button levels to released and loads the register defaults.
`include "three_button_debounce_long_press_macros.svh"

module three_button_debounce_long_press #(
    parameter int TIME_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             plus_raw,
    input  logic                             minus_raw,
    input  logic                             reset_raw,
    input  logic                             display_on,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       wake_count,
    output logic                             plus_event,
    output logic                             minus_event,
    output logic                             short_reset_event,
    output logic                             format_event,
    input  logic                             cfg_wr_en,
    input  logic [tbdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbdlp_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [tbdlp_pkg::DEBOUNCE_W-1:0] debounce_ticks_reg;
    logic [tbdlp_pkg::WINDOW_W-1:0]   wake_window_ticks_reg;
    logic [tbdlp_pkg::HOLD_W-1:0]     hold_ticks_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_plus_reg;
    logic                 s1_minus_reg;
    logic                 s1_reset_reg;
    logic                 s1_disp_reg;
    logic                 s1_fire;
    logic                 in_accept;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tbdlp_pkg::tick_res_t out_res_reg;
    tbdlp_pkg::tick_res_t res;
    tbdlp_pkg::db_evt_t   plus_evt;
    tbdlp_pkg::db_evt_t   minus_evt;
    tbdlp_pkg::db_evt_t   reset_evt;
    logic [TIME_BITS-1:0] now;
    logic                 fmt_with_short;
    logic                 btn_evt_out;
    logic                 s1_stall;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg    <= tbdlp_pkg::DEBOUNCE_RESET;
            wake_window_ticks_reg <= tbdlp_pkg::WINDOW_RESET;
            hold_ticks_reg        <= tbdlp_pkg::HOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tbdlp_pkg::CFG_DEBOUNCE:
                begin
                    debounce_ticks_reg <= cfg_data[tbdlp_pkg::DEBOUNCE_W-1:0];
                end
                tbdlp_pkg::CFG_WINDOW:
                begin
                    wake_window_ticks_reg <= cfg_data[tbdlp_pkg::WINDOW_W-1:0];
                end
                tbdlp_pkg::CFG_HOLD:
                begin
                    hold_ticks_reg <= cfg_data[tbdlp_pkg::HOLD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register is free.
    always_comb
    begin
        s1_fire        = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready       = !s1_valid_reg || s1_fire;
        in_accept      = in_valid && in_ready;
        s1_valid_next  = in_accept || (s1_valid_reg && !s1_fire);
        out_valid_next = s1_fire || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_plus_reg  <= plus_raw;
            s1_minus_reg <= minus_raw;
            s1_reset_reg <= reset_raw;
            s1_disp_reg  <= display_on;
        end
    end

    // Per-button debounce.
    tbdlp_debounce #(.TIME_BITS(TIME_BITS)) u_plus_db (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_fire),
        .raw            (s1_plus_reg),
        .now            (now),
        .debounce_ticks (debounce_ticks_reg),
        .evt            (plus_evt)
    );

    tbdlp_debounce #(.TIME_BITS(TIME_BITS)) u_minus_db (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_fire),
        .raw            (s1_minus_reg),
        .now            (now),
        .debounce_ticks (debounce_ticks_reg),
        .evt            (minus_evt)
    );

    tbdlp_debounce #(.TIME_BITS(TIME_BITS)) u_reset_db (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_fire),
        .raw            (s1_reset_reg),
        .now            (now),
        .debounce_ticks (debounce_ticks_reg),
        .evt            (reset_evt)
    );

    // Wake guard, hold tracking and tick counter.
    tbdlp_ctrl #(.TIME_BITS(TIME_BITS)) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (s1_fire),
        .display_on        (s1_disp_reg),
        .plus_evt          (plus_evt),
        .minus_evt         (minus_evt),
        .reset_evt         (reset_evt),
        .wake_window_ticks (wake_window_ticks_reg),
        .hold_ticks        (hold_ticks_reg),
        .now               (now),
        .res               (res)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign wake_count        = out_res_reg.wake_count;
    assign plus_event        = out_res_reg.plus_event;
    assign minus_event       = out_res_reg.minus_event;
    assign short_reset_event = out_res_reg.short_reset_event;
    assign format_event      = out_res_reg.format_event;

    // Terms watched by the checks below.
    assign fmt_with_short = out_valid && format_event && short_reset_event;
    assign btn_evt_out    = out_valid && (plus_event || minus_event);
    assign s1_stall       = s1_valid_reg && !s1_fire;

    // A hold ends either with a format event or a short reset, never both at once.
    `TBDLP_NEVER(a_fmt_short_excl, clk, rst_n, fmt_with_short, "format and short reset together")
    // Button events need the display on, so no wake can share their tick.
    `TBDLP_ASSERT(a_evt_no_wake, clk, rst_n, btn_evt_out |-> (wake_count == 2'd0), "event with wake")
    // A request waiting in the input register is kept until it moves on.
    `TBDLP_ASSERT(a_s1_hold, clk, rst_n, s1_stall |=> s1_valid_reg, "input register lost a request")

endmodule

// ----- hw/rtl/tbdlp_debounce.sv -----
// Timestamp debounce of one active-low button.
module tbdlp_debounce #(
    parameter int TIME_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            raw,
    input  logic [TIME_BITS-1:0]            now,
    input  logic [tbdlp_pkg::DEBOUNCE_W-1:0] debounce_ticks,
    output tbdlp_pkg::db_evt_t              evt
);

    logic                 level_reg;
    logic                 level_next;
    logic [TIME_BITS-1:0] stamp_reg;
    logic [TIME_BITS-1:0] stamp_next;
    logic [TIME_BITS-1:0] elapsed;
    logic                 differs;
    logic                 changed;

    // A differing reading is taken once it has lasted the debounce time.
    assign elapsed = now - stamp_reg;
    assign differs = (raw != level_reg);
    assign changed = differs && (elapsed >= TIME_BITS'(debounce_ticks));

    assign evt.pressed  = changed && !raw;
    assign evt.released = changed && raw;

    // The stamp follows the current time unless a change is still pending.
    always_comb
    begin
        level_next = changed ? raw : level_reg;
        stamp_next = (!differs || changed) ? now : stamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b1;
            stamp_reg <= '0;
        end
        else if (step)
        begin
            level_reg <= level_next;
            stamp_reg <= stamp_next;
        end
    end

endmodule

// ----- hw/rtl/tbdlp_ctrl.sv -----
// Tick counter, wake guard and reset hold tracking.
module tbdlp_ctrl #(
    parameter int TIME_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic                           display_on,
    input  tbdlp_pkg::db_evt_t             plus_evt,
    input  tbdlp_pkg::db_evt_t             minus_evt,
    input  tbdlp_pkg::db_evt_t             reset_evt,
    input  logic [tbdlp_pkg::WINDOW_W-1:0] wake_window_ticks,
    input  logic [tbdlp_pkg::HOLD_W-1:0]   hold_ticks,
    output logic [TIME_BITS-1:0]           now,
    output tbdlp_pkg::tick_res_t           res
);

    logic [TIME_BITS-1:0] tick_time_reg;
    logic [TIME_BITS-1:0] wake_stamp_reg;
    logic [TIME_BITS-1:0] wake_stamp_next;
    logic [TIME_BITS-1:0] hold_start_reg;
    logic [TIME_BITS-1:0] hold_start_next;
    logic                 holding_reg;
    logic                 holding_next;
    logic                 format_done_reg;
    logic                 format_done_next;
    logic                 wake_ok;
    logic                 hold_begin;
    logic                 hold_end;
    logic                 hold_reached;
    logic                 any_wake;

    assign now = tick_time_reg;

    // Presses count only once the guard window after the last wake has passed.
    assign wake_ok = (tick_time_reg - wake_stamp_reg) > TIME_BITS'(wake_window_ticks);

    // Wake events, button events and the reset hold of one tick.
    always_comb
    begin
        res.wake_count = 2'(plus_evt.pressed && !display_on)
                       + 2'(minus_evt.pressed && !display_on)
                       + 2'(reset_evt.pressed && !display_on);
        any_wake       = !display_on
                       && (plus_evt.pressed || minus_evt.pressed || reset_evt.pressed);
        res.plus_event  = plus_evt.pressed && display_on && wake_ok;
        res.minus_event = minus_evt.pressed && display_on && wake_ok;

        // Reset hold: a guarded press starts it, a release ends it.
        hold_begin = reset_evt.pressed && display_on && wake_ok;
        hold_end   = reset_evt.released && holding_reg;
        res.short_reset_event = hold_end && !format_done_reg;

        if (hold_begin)
        begin
            hold_reached     = (hold_ticks == '0);
            hold_start_next  = tick_time_reg;
            holding_next     = 1'b1;
            format_done_next = 1'b0;
        end
        else
        begin
            hold_reached     = (tick_time_reg - hold_start_reg) >= TIME_BITS'(hold_ticks);
            hold_start_next  = hold_start_reg;
            holding_next     = holding_reg && !hold_end;
            format_done_next = format_done_reg;
        end

        res.format_event = holding_next && !format_done_next && hold_reached;
        if (res.format_event)
        begin
            format_done_next = 1'b1;
        end

        wake_stamp_next = any_wake ? tick_time_reg : wake_stamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg   <= '0;
            wake_stamp_reg  <= '0;
            hold_start_reg  <= '0;
            holding_reg     <= 1'b0;
            format_done_reg <= 1'b0;
        end
        else if (step)
        begin
            tick_time_reg   <= tick_time_reg + TIME_BITS'(1);
            wake_stamp_reg  <= wake_stamp_next;
            hold_start_reg  <= hold_start_next;
            holding_reg     <= holding_next;
            format_done_reg <= format_done_next;
        end
    end

endmodule
